@@ sv/ptes_pkg.sv @@
// ============================================================================
// ptes_pkg
// Shared types, effect descriptors and constants of the preset tone synth.
// ============================================================================
package ptes_pkg;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_TONE   = 2'd0;
    localparam kind_t KIND_SWEEP  = 2'd1;
    localparam kind_t KIND_JINGLE = 2'd2;
    localparam kind_t KIND_SWELL  = 2'd3;

    localparam int NUM_FX   = 9;
    localparam int DIV_W    = 32;  // dividend and quotient width of the serial divider
    localparam int DVS_W    = 16;  // divisor width
    localparam int DIV_CW   = 6;   // step counter width, holds DIV_W

    localparam logic [15:0] AMP_DEN     = 16'd1000;
    localparam logic [15:0] FULL_SCALE  = 16'd32767;
    localparam logic [13:0] SWELL_GAIN  = 14'd13107;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam logic [4:0] FX_ALT_A = 5'd19;
    localparam logic [4:0] FX_ALT_B = 5'd20;

    typedef struct packed {
        kind_t              kind;
        logic [9:0]         ms;
        logic [9:0]         f0;
        logic signed [10:0] df;
        logic [8:0]         vol;
        logic [5:0]         fade_end;
    } fx_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] slot;
    } slot_t;

    function automatic fx_t fx_of(input logic [3:0] slot);
        fx_t d;
        case (slot)
            4'd0:    d = '{KIND_TONE,   10'd55,  10'd880,  11'sd0,    9'd220, 6'd0};
            4'd1:    d = '{KIND_TONE,   10'd80,  10'd520,  11'sd0,    9'd200, 6'd0};
            4'd2:    d = '{KIND_SWEEP,  10'd140, 10'd700, -11'sd550,  9'd260, 6'd0};
            4'd3:    d = '{KIND_TONE,   10'd220, 10'd90,   11'sd0,    9'd380, 6'd50};
            4'd4:    d = '{KIND_JINGLE, 10'd350, 10'd0,    11'sd0,    9'd220, 6'd0};
            4'd5:    d = '{KIND_SWEEP,  10'd900, 10'd280, -11'sd200,  9'd300, 6'd0};
            4'd6:    d = '{KIND_SWELL,  10'd180, 10'd200,  11'sd400,  9'd200, 6'd0};
            4'd7:    d = '{KIND_TONE,   10'd280, 10'd220,  11'sd0,    9'd400, 6'd50};
            default: d = '{KIND_TONE,   10'd180, 10'd110,  11'sd0,    9'd350, 6'd0};
        endcase
        return d;
    endfunction

    function automatic slot_t slot_of(input logic [4:0] effect);
        slot_t s;
        s.ok   = 1'b1;
        s.slot = effect[3:0];
        if (effect == FX_ALT_A) begin
            s.slot = 4'd7;
        end else if (effect == FX_ALT_B) begin
            s.slot = 4'd8;
        end else if (effect > 5'd6) begin
            s.ok = 1'b0;
        end
        return s;
    endfunction

    function automatic logic [9:0] jingle_note(input logic [1:0] sel);
        logic [9:0] f;
        case (sel)
            2'd0:    f = 10'd330;
            2'd1:    f = 10'd440;
            2'd2:    f = 10'd550;
            default: f = 10'd660;
        endcase
        return f;
    endfunction

endpackage

@@ sv/ptes_div.sv @@
// ============================================================================
// ptes_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ============================================================================
module ptes_div
    import ptes_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    logic              busy_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [DVS_W:0]    rem_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [DVS_W-1:0]  dvs_reg;

    logic [DVS_W:0]    rem_shift;
    logic [DVS_W:0]    rem_next;
    logic              qbit;

    always_comb begin
        rem_shift = {rem_reg[DVS_W-1:0], quo_reg[DIV_W-1]};
        qbit      = (rem_shift >= {1'b0, dvs_reg});
        rem_next  = qbit ? (rem_shift - {1'b0, dvs_reg}) : rem_shift;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CW'(DIV_W);
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                quo_reg <= {quo_reg[DIV_W-2:0], qbit};
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg - DIV_CW'(1);
                if (cnt_reg == DIV_CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ sv/preset_tone_effect_synth_top.sv @@
// ============================================================================
// preset_tone_effect_synth_top
// Preset sound-effect generator: nine synthesized effects, one sample a tick.
// ============================================================================
// Input channel s_*: a word with s_action 0 is a trigger that starts effect
// s_effect (unknown numbers and triggers while muted are dropped, no output
// word). A word with s_action 1 is a tick and yields exactly one output word
// on m_*: m_sample, m_playing and m_last.
// cfg_wr_en/cfg_wr_data write the mute bit; write it only while idle.
// An idle or muted tick goes straight to the output stage. A playing tick
// runs two passes of the bit-serial divider (progress, then amplitude), a
// modular multiply over the sample index and a phase division of PHASE_BITS
// bits, plus table lookup and scaling, with one more lookup for the swell.
// One word is worked on at a time; s_ready is high whenever the sequencer is
// idle, also while a finished word waits in the output register.
// When m_ready is low the output word holds and the next tick waits in the
// sequencer until the output register frees up.
// Reset (synchronous, aresetn low) leaves the block idle and unmuted.
// ============================================================================
module preset_tone_effect_synth_top
    import ptes_pkg::*;
#(
    parameter int SAMPLE_RATE      = 44100,
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int PHASE_BITS       = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [4:0]  s_effect,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [15:0] m_sample,
    output logic        m_playing,
    output logic        m_last
);

    localparam int LD = $clog2(SINE_TABLE_DEPTH);
    localparam int PW = LD + 2;    // full-wave position width: quadrant bits over the table offset
    localparam int IW = LD + 1;    // table index width
    localparam longint unsigned M_MOD = 64'd65536 * 64'(SAMPLE_RATE);
    localparam int MW = $clog2(M_MOD) + 1;
    localparam int RW = MW + 2;
    localparam int FQW = 26;

    typedef logic [14:0] rom_t [0:SINE_TABLE_DEPTH];

    function automatic rom_t build_rom();
        rom_t rom;
        longint unsigned x, term, sum;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x    = HALF_PI_Q30 * 64'(k) / SINE_TABLE_DEPTH;
            term = x;
            sum  = x;
            for (int n = 1; n <= 7; n++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                case (n)
                    1:       term = term / 6;
                    2:       term = term / 20;
                    3:       term = term / 42;
                    4:       term = term / 72;
                    5:       term = term / 110;
                    6:       term = term / 156;
                    default: term = term / 210;
                endcase
                if ((n & 1) != 0) sum = sum - term;
                else sum = sum + term;
            end
            rom[k] = 15'((sum * 64'd32767 + (64'd1 << 29)) >> 30);
        end
        return rom;
    endfunction

    function automatic logic [15:0] len_calc(input logic [9:0] ms);
        longint unsigned n;
        n = 64'(SAMPLE_RATE) * 64'(ms) / 1000;
        if (n > 64'd65535) n = 64'd65535;
        if (n == 64'd0) n = 64'd1;
        return 16'(n);
    endfunction

    localparam rom_t SINE_ROM = build_rom();
    localparam logic [15:0] FX_LEN [0:NUM_FX-1] = '{
        len_calc(fx_of(4'd0).ms), len_calc(fx_of(4'd1).ms), len_calc(fx_of(4'd2).ms),
        len_calc(fx_of(4'd3).ms), len_calc(fx_of(4'd4).ms), len_calc(fx_of(4'd5).ms),
        len_calc(fx_of(4'd6).ms), len_calc(fx_of(4'd7).ms), len_calc(fx_of(4'd8).ms)
    };

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DIVP = 4'd1;
    localparam logic [3:0] ST_FQ   = 4'd2;
    localparam logic [3:0] ST_SWH  = 4'd3;
    localparam logic [3:0] ST_AMPN = 4'd4;
    localparam logic [3:0] ST_DIVA = 4'd5;
    localparam logic [3:0] ST_MOD  = 4'd6;
    localparam logic [3:0] ST_PH   = 4'd7;
    localparam logic [3:0] ST_SIN  = 4'd8;
    localparam logic [3:0] ST_MUL  = 4'd9;
    localparam logic [3:0] ST_OUT  = 4'd10;

    // control state
    logic [3:0]  state_reg;
    logic        muted_reg;
    logic        active_reg;
    logic [3:0]  slot_reg;
    logic [15:0] index_reg;
    logic [15:0] len_reg;
    logic        m_valid_reg;
    logic [5:0]  cnt_reg;

    // datapath
    logic [15:0]           work_i_reg;
    logic                  work_last_reg;
    logic [15:0]           p_reg;
    logic [FQW-1:0]        fq_reg;
    logic [14:0]           h_reg;
    logic [15:0]           amp_reg;
    logic [RW-1:0]         r_reg;
    logic [PHASE_BITS-1:0] q_reg;
    logic [14:0]           mag_reg;
    logic                  neg_reg;
    logic [14:0]           val_reg;
    logic                  res_play_reg;
    logic signed [15:0]    m_sample_reg;
    logic                  m_playing_reg;
    logic                  m_last_reg;

    fx_t   fx;
    slot_t trig_slot;
    logic  accept;
    logic  tick_go;
    logic  fin;

    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    logic             div_done;
    logic [DIV_W-1:0] div_quotient;

    assign fx        = fx_of(slot_reg);
    assign trig_slot = slot_of(s_effect);
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign fin       = ({1'b0, index_reg} + 17'd1) >= {1'b0, len_reg};
    assign tick_go   = accept && s_action && active_reg && !muted_reg;

    // frequency and amplitude numerators
    logic signed [27:0] fq_lin;
    logic [16:0]        p_inv;
    logic [DIV_W-1:0]   fade_num;
    logic [DIV_W-1:0]   swell_num;

    always_comb begin
        fq_lin    = $signed({2'b00, fx.f0, 16'd0}) + fx.df * $signed({1'b0, p_reg});
        p_inv     = 17'd65536 - {1'b0, p_reg};
        fade_num  = DIV_W'(fx.vol) * DIV_W'(p_inv) + DIV_W'(fx.fade_end) * DIV_W'(p_reg);
        swell_num = DIV_W'(SWELL_GAIN) * DIV_W'(h_reg);
    end

    // divider feeds: progress at tick start, amplitude scaling later
    always_comb begin
        div_start    = tick_go || (state_reg == ST_AMPN);
        div_dividend = {index_reg, 16'd0};
        div_divisor  = len_reg;
        if (state_reg == ST_AMPN) begin
            div_dividend = (fx.kind == KIND_SWELL) ? swell_num : fade_num;
            div_divisor  = (fx.kind == KIND_SWELL) ? FULL_SCALE : AMP_DEN;
        end
    end

    ptes_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // sine lookup, shared by the swell envelope and the tone itself
    logic [PHASE_BITS+PW-1:0] ph_wide;
    logic [16+PW-1:0]         sw_wide;
    logic [PW-1:0]            sin_pos;
    logic [IW-1:0]            rom_addr;
    logic [14:0]              sin_mag;
    logic                     sin_neg;

    always_comb begin
        ph_wide  = {q_reg, {PW{1'b0}}} >> PHASE_BITS;
        sw_wide  = {p_reg, {PW{1'b0}}} >> 17;
        sin_pos  = (state_reg == ST_SWH) ? sw_wide[PW-1:0] : ph_wide[PW-1:0];
        rom_addr = sin_pos[LD] ? (IW'(SINE_TABLE_DEPTH) - {1'b0, sin_pos[LD-1:0]})
                               : {1'b0, sin_pos[LD-1:0]};
        sin_mag  = SINE_ROM[rom_addr];
        sin_neg  = sin_pos[PW-1];
    end

    // modular multiply step: r = 2r + bit*fq, kept below the phase modulus
    logic [RW-1:0] mod_sum;
    logic [RW-1:0] mod_next;
    logic [RW-1:0] ph_dbl;
    logic          ph_bit;
    logic [RW-1:0] ph_next;

    always_comb begin
        mod_sum = {r_reg[RW-2:0], 1'b0} + (work_i_reg[15] ? RW'(fq_reg) : RW'(0));
        if (mod_sum >= RW'(2 * M_MOD)) begin
            mod_next = mod_sum - RW'(2 * M_MOD);
        end else if (mod_sum >= RW'(M_MOD)) begin
            mod_next = mod_sum - RW'(M_MOD);
        end else begin
            mod_next = mod_sum;
        end
        ph_dbl  = {r_reg[RW-2:0], 1'b0};
        ph_bit  = (ph_dbl >= RW'(M_MOD));
        ph_next = ph_bit ? (ph_dbl - RW'(M_MOD)) : ph_dbl;
    end

    logic [31:0] amp_prod;
    assign amp_prod = 32'(amp_reg) * 32'(mag_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            muted_reg   <= 1'b0;
            active_reg  <= 1'b0;
            slot_reg    <= '0;
            index_reg   <= '0;
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                muted_reg <= cfg_wr_data;
            end
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept && !s_action) begin
                        if (!muted_reg && trig_slot.ok) begin
                            slot_reg   <= trig_slot.slot;
                            index_reg  <= '0;
                            len_reg    <= FX_LEN[trig_slot.slot];
                            active_reg <= 1'b1;
                        end
                    end else if (accept) begin
                        work_i_reg    <= index_reg;
                        work_last_reg <= fin;
                        res_play_reg  <= 1'b0;
                        val_reg       <= '0;
                        neg_reg       <= 1'b0;
                        if (active_reg) begin
                            index_reg <= index_reg + 16'd1;
                            if (fin) active_reg <= 1'b0;
                        end
                        state_reg <= tick_go ? ST_DIVP : ST_OUT;
                    end
                end
                ST_DIVP: begin
                    if (div_done) begin
                        p_reg     <= div_quotient[15:0];
                        state_reg <= ST_FQ;
                    end
                end
                ST_FQ: begin
                    if (fx.kind == KIND_JINGLE) begin
                        fq_reg <= {jingle_note(p_reg[15:14]), 16'd0};
                    end else begin
                        fq_reg <= fq_lin[FQW-1:0];
                    end
                    state_reg <= (fx.kind == KIND_SWELL) ? ST_SWH : ST_AMPN;
                end
                ST_SWH: begin
                    h_reg     <= sin_neg ? 15'd0 : sin_mag;
                    state_reg <= ST_AMPN;
                end
                ST_AMPN: begin
                    state_reg <= ST_DIVA;
                end
                ST_DIVA: begin
                    if (div_done) begin
                        amp_reg   <= div_quotient[15:0];
                        r_reg     <= '0;
                        cnt_reg   <= 6'd16;
                        state_reg <= ST_MOD;
                    end
                end
                ST_MOD: begin
                    r_reg      <= mod_next;
                    work_i_reg <= {work_i_reg[14:0], 1'b0};
                    cnt_reg    <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1) begin
                        cnt_reg   <= 6'(PHASE_BITS);
                        state_reg <= ST_PH;
                    end
                end
                ST_PH: begin
                    r_reg   <= ph_next;
                    q_reg   <= {q_reg[PHASE_BITS-2:0], ph_bit};
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1) begin
                        state_reg <= ST_SIN;
                    end
                end
                ST_SIN: begin
                    mag_reg   <= sin_mag;
                    neg_reg   <= sin_neg;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    val_reg      <= amp_prod[30:16];
                    res_play_reg <= 1'b1;
                    state_reg    <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg   <= 1'b1;
                        m_sample_reg  <= neg_reg ? -$signed({1'b0, val_reg})
                                                 : $signed({1'b0, val_reg});
                        m_playing_reg <= res_play_reg;
                        m_last_reg    <= res_play_reg && work_last_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_sample  = m_sample_reg;
    assign m_playing = m_playing_reg;
    assign m_last    = m_last_reg;

endmodule

@@ sv/ptes_check.sv @@
// ============================================================================
// ptes_check
// Port-level checks of the preset tone synth, bound to the top level.
// ============================================================================
module ptes_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_action,
    input logic        m_valid,
    input logic        m_ready,
    input logic signed [15:0] m_sample,
    input logic        m_playing,
    input logic        m_last
);

    // no output word survives reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output word valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample))
        else $error("stalled word changed");

    // a silent word carries a zero sample and no end flag
    a_silent_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_playing |-> m_sample == 16'sd0 && !m_last)
        else $error("silent word not zero");

    // a trigger word never produces an output word by itself
    a_trigger_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_action && !m_valid |=> !m_valid)
        else $error("output word after trigger");

endmodule

bind preset_tone_effect_synth_top ptes_check u_ptes_check (.*);

@@ test/preset_tone_effect_synth_top_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// preset_tone_effect_synth_top_tb
// Self-checking bench: triggers and ticks go in on s_*, samples come out on m_*.
// A cycle-free predictor of the nine effects works out each sample and the
// monitor checks every output word against it, under mute changes, idling and stalls.
// ============================================================================
module preset_tone_effect_synth_top_tb
    import ptes_pkg::*;
;

    localparam int RATE  = 44100;
    localparam int DEPTH = 256;
    localparam int PBITS = 16;
    localparam int DRAIN_CYCLES = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam logic ACT_TRIG = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef struct packed {
        logic       act;
        logic [4:0] eff;
    } word_t;

    typedef struct packed {
        logic signed [15:0] smp;
        logic               ply;
        logic               lst;
    } sample_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic cfg_wr_data = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_action = 1'b0;
    logic [4:0] s_effect = 5'd0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [15:0] m_sample;
    logic m_playing;
    logic m_last;

    preset_tone_effect_synth_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action), .s_effect(s_effect),
        .m_valid(m_valid), .m_ready(m_ready), .m_sample(m_sample),
        .m_playing(m_playing), .m_last(m_last)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // effect descriptors, slot order
    kind_t fx_kind [9] = '{KIND_TONE, KIND_TONE, KIND_SWEEP, KIND_TONE, KIND_JINGLE,
                           KIND_SWEEP, KIND_SWELL, KIND_TONE, KIND_TONE};
    int fx_ms  [9] = '{55, 80, 140, 220, 350, 900, 180, 280, 180};
    int fx_f0  [9] = '{880, 520, 700, 90, 0, 280, 200, 220, 110};
    int fx_df  [9] = '{0, 0, -550, 0, 0, -200, 400, 0, 0};
    int fx_vol [9] = '{220, 200, 260, 380, 220, 300, 200, 400, 350};
    int fx_end [9] = '{0, 0, 0, 50, 0, 0, 0, 50, 0};
    int note_hz [4] = '{330, 440, 550, 660};

    logic [15:0] qsine [DEPTH+1];

    // predictor state
    logic        mute_q = 1'b0;
    logic [4:0]  cur_fx = 5'd0;
    logic [15:0] pos_idx = 16'd0;
    logic [15:0] fx_len = 16'd0;
    logic        busy = 1'b0;

    word_t   pend_words [$];
    sample_t want_q [$];
    int idle_pct = 0;
    int stall_pct = 0;
    bit in_took = 1'b0;
    bit hold_go = 1'b0;
    bit hold_done = 1'b0;
    int hold_cnt = 0;
    int n_err = 0;
    int n_checked = 0;
    int n_played = 0;
    int n_last = 0;
    int n_words = 0;

    function automatic int slot_for(input logic [4:0] e);
        if (e <= 5'd6) return int'(e);
        if (e == 5'd19) return 7;
        if (e == 5'd20) return 8;
        return -1;
    endfunction

    function automatic int signed sine_at(input longint unsigned pos);
        longint unsigned quad, idx;
        int signed m;
        quad = (pos / DEPTH) & 3;
        idx  = pos % DEPTH;
        m = (quad & 1) ? int'(qsine[DEPTH - idx]) : int'(qsine[idx]);
        return (quad & 2) ? -m : m;
    endfunction

    // long division of (fq*i mod rate*2^16) into PBITS fractional bits
    function automatic longint unsigned phase_of(input longint unsigned fq,
                                                 input longint unsigned i);
        longint unsigned m, r, q;
        m = 64'd65536 * RATE;
        r = (fq * i) % m;
        q = 0;
        for (int b = 0; b < PBITS; b++) begin
            r = r << 1;
            q = q << 1;
            if (r >= m) begin
                r = r - m;
                q = q | 1;
            end
        end
        return q;
    endfunction

    function automatic logic signed [15:0] effect_sample(input int slot,
                                                         input longint unsigned i,
                                                         input longint unsigned n);
        longint unsigned p, amp, fq, pos, mag, val;
        int signed s, h;
        p = (i << 16) / n;
        if (p > 65535) p = 65535;
        if (fx_kind[slot] == KIND_JINGLE)
            fq = longint'(note_hz[(p >> 14) & 3]) << 16;
        else if (fx_df[slot] < 0)
            fq = (longint'(fx_f0[slot]) << 16) - longint'(-fx_df[slot]) * p;
        else
            fq = (longint'(fx_f0[slot]) << 16) + longint'(fx_df[slot]) * p;
        if (fx_kind[slot] == KIND_SWELL) begin
            h = sine_at((p * 4 * DEPTH) >> 17);
            amp = (64'd13107 * longint'(h < 0 ? 0 : h)) / 32767;
        end else begin
            amp = (longint'(fx_vol[slot]) * (65536 - p) + longint'(fx_end[slot]) * p) / 1000;
        end
        pos = (phase_of(fq, i) * 4 * DEPTH) >> PBITS;
        s = sine_at(pos);
        mag = longint'(s < 0 ? -s : s);
        val = (amp * mag) >> 16;
        return s < 0 ? -16'(val) : 16'(val);
    endfunction

    // advance the predictor by one accepted word
    task automatic predict_word(input word_t w);
        sample_t r;
        int slot;
        longint unsigned n;
        bit fin;
        r = '0;
        if (w.act == ACT_TRIG) begin
            slot = slot_for(w.eff);
            if (!mute_q && slot >= 0) begin
                n = longint'(RATE) * fx_ms[slot] / 1000;
                if (n > 65535) n = 65535;
                if (n == 0) n = 1;
                cur_fx = w.eff;
                pos_idx = 16'd0;
                fx_len = 16'(n);
                busy = 1'b1;
            end
            return;
        end
        if (busy) begin
            slot = slot_for(cur_fx);
            n = (fx_len != 0) ? fx_len : 1;
            fin = (longint'(pos_idx) + 1 >= n);
            if (!mute_q && slot >= 0) begin
                r.smp = effect_sample(slot, pos_idx, n);
                r.ply = 1'b1;
                r.lst = fin;
            end
            pos_idx = pos_idx + 16'd1;
            if (fin || slot < 0) busy = 1'b0;
        end
        want_q.push_back(r);
    endtask

    function automatic void build_sine();
        longint unsigned x, term, sum;
        for (int k = 0; k <= DEPTH; k++) begin
            x = HALF_PI_Q30 * k / DEPTH;
            term = x;
            sum = x;
            for (int n = 1; n <= 7; n++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / ((2 * n) * (2 * n + 1));
                if (n & 1) sum = sum - term;
                else sum = sum + term;
            end
            qsine[k] = 16'((sum * 64'd32767 + (64'd1 << 29)) >> 30);
        end
    endfunction

    // monitor: both channels sampled at the rising edge
    always @(posedge aclk) begin
        sample_t w;
        in_took = aresetn && s_valid && s_ready;
        if (in_took) predict_word('{act: s_action, eff: s_effect});
        if (aresetn && m_valid && m_ready) begin
            if (want_q.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("unexpected word: sample %0d playing %0b last %0b",
                             m_sample, m_playing, m_last);
            end else begin
                w = want_q.pop_front();
                n_checked++;
                if (w.ply) n_played++;
                if (w.lst) n_last++;
                if (m_sample !== w.smp || m_playing !== w.ply || m_last !== w.lst) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch word %0d: exp %0d/%0b/%0b got %0d/%0b/%0b",
                                 n_checked, w.smp, w.ply, w.lst,
                                 m_sample, m_playing, m_last);
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge aclk) begin
        if (hold_go && !hold_done) begin
            if (hold_cnt == HOLD_CYCLES) hold_done <= 1'b1;
            else hold_cnt <= hold_cnt + 1;
        end
    end

    // driver: inputs change at the falling edge
    always @(negedge aclk) begin
        word_t w;
        if (aresetn) begin
            if (!s_valid || in_took) begin
                if (pend_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    w = pend_words.pop_front();
                    s_valid <= 1'b1;
                    s_action <= w.act;
                    s_effect <= w.eff;
                    n_words++;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= (hold_go && !hold_done) ? 1'b0 : ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic add_word(input logic act, input logic [4:0] eff);
        pend_words.push_back('{act: act, eff: eff});
    endtask

    task automatic add_ticks(input int cnt);
        for (int k = 0; k < cnt; k++) add_word(ACT_TICK, 5'($urandom));
    endtask

    // mostly trigger-then-run sequences, some noise
    task automatic add_random(input int cnt);
        int k;
        int run;
        logic [4:0] e;
        k = 0;
        while (k < cnt) begin
            if ($urandom_range(99) < 12) begin
                add_word(1'($urandom), 5'($urandom));
                k++;
            end else begin
                if ($urandom_range(3) == 0) e = 5'($urandom);
                else begin
                    e = 5'($urandom_range(8));
                    if (e == 5'd7) e = 5'd19;
                    if (e == 5'd8) e = 5'd20;
                end
                run = ($urandom_range(19) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 30);
                add_word(ACT_TRIG, e);
                add_ticks(run);
                k += run + 1;
            end
        end
    endtask

    task automatic drain();
        while (pend_words.size() != 0 || s_valid || want_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mute(input logic val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= val;
        mute_q = val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        build_sine();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: idle tick, ignored numbers, every effect, replacement
        add_word(ACT_TICK, 5'd31);
        add_word(ACT_TRIG, 5'd7);
        add_word(ACT_TICK, 5'd0);
        for (int e = 0; e < 9; e++) begin
            add_word(ACT_TRIG, (e == 7) ? 5'd19 : (e == 8) ? 5'd20 : 5'(e));
            add_ticks(2);
        end
        add_word(ACT_TRIG, 5'd18);
        add_word(ACT_TRIG, 5'd21);
        add_word(ACT_TICK, 5'd0);
        drain();

        // one effect run for a stretch of samples
        add_word(ACT_TRIG, 5'd0);
        add_ticks(20);
        drain();

        write_mute(1'b1);
        add_word(ACT_TRIG, 5'd3);
        add_ticks(3);
        drain();
        write_mute(1'b0);
        add_ticks(3);
        drain();

        idle_pct = 48;
        add_random(120);
        drain();

        write_mute(1'b1);
        idle_pct = 0;
        stall_pct = 48;
        add_random(80);
        drain();

        write_mute(1'b0);
        stall_pct = 0;
        hold_go = 1'b1;
        add_random(110);
        drain();

        idle_pct = 18;
        stall_pct = 18;
        add_random(120);
        drain();

        write_mute(1'b1);
        idle_pct = 0;
        stall_pct = 0;
        add_random(30);
        drain();
        write_mute(1'b0);
        add_random(60);
        drain();

        $display("run covered %0d input words, %0d output words checked", n_words, n_checked);
        $display("%0d audible samples, %0d end-of-effect flags, %0d mismatches",
                 n_played, n_last, n_err);
        if (n_err == 0 && want_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d words outstanding", want_q.size());
        $display("FAIL");
        $finish;
    end

endmodule
